// ----- rtl/core/cfd_pkg.sv -----
// shared types, header constants and the byte-wide crc-16 fold for the deframer
// used by cfd_parse and crc16_frame_deframer_top; depends on nothing
package cfd_pkg;

	localparam logic [7:0]  HDR_FIRST  = 8'hAA;
	localparam logic [7:0]  HDR_SECOND = 8'h55;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam int          CRC_BITS   = 8;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 72;
	localparam int KIND_W      = 2;

	typedef enum logic [2:0] {
		PH_HUNT1 = 3'd0,
		PH_HUNT2 = 3'd1,
		PH_ADDR  = 3'd2,
		PH_FUNC  = 3'd3,
		PH_LEN   = 3'd4,
		PH_DATA  = 3'd5,
		PH_CRCLO = 3'd6,
		PH_CRCHI = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [7:0]  byte_index;
		logic [7:0]  address;
		logic [7:0]  function_code;
		logic [7:0]  payload_length;
		logic [15:0] received_crc;
		logic [15:0] computed_crc;
	} result_t;

	// reflected crc-16, one byte folded lsb first
	function automatic logic [15:0] crc_fold(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int k = 0; k < CRC_BITS; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// crc after the two header bytes, fixed for every frame
	localparam logic [15:0] CRC_AFTER_HDR = crc_fold(crc_fold(CRC_INIT, HDR_FIRST), HDR_SECOND);

endpackage

// ----- rtl/core/cfd_parse.sv -----
// frame state machine: header hunt, field capture, running crc and result forming
// depends on cfd_pkg
module cfd_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	output logic             has_result,
	output cfd_pkg::result_t result
);

	cfd_pkg::phase_t phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  addr_q, addr_d;
	logic [7:0]  func_q, func_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [15:0] crc_fold_byte;
	logic [7:0]  count_inc;
	logic [15:0] rx_crc;

	assign crc_fold_byte = cfd_pkg::crc_fold(crc_q, rx_byte);
	assign count_inc     = count_q + 8'd1;
	assign rx_crc        = {rx_byte, crc_lo_q};

	always_comb begin
		phase_d    = phase_q;
		crc_d      = crc_q;
		addr_d     = addr_q;
		func_d     = func_q;
		len_d      = len_q;
		count_d    = count_q;
		crc_lo_d   = crc_lo_q;
		has_result = 1'b0;
		result     = '0;
		result.address        = addr_q;
		result.function_code  = func_q;
		result.payload_length = len_q;
		unique case (phase_q)
			cfd_pkg::PH_HUNT1: begin
				if (rx_byte == cfd_pkg::HDR_FIRST) begin
					phase_d = cfd_pkg::PH_HUNT2;
				end
			end
			cfd_pkg::PH_HUNT2: begin
				// a repeated first header byte keeps waiting for the second
				if (rx_byte == cfd_pkg::HDR_SECOND) begin
					crc_d   = cfd_pkg::CRC_AFTER_HDR;
					phase_d = cfd_pkg::PH_ADDR;
				end else if (rx_byte != cfd_pkg::HDR_FIRST) begin
					phase_d = cfd_pkg::PH_HUNT1;
				end
			end
			cfd_pkg::PH_ADDR: begin
				addr_d  = rx_byte;
				crc_d   = crc_fold_byte;
				phase_d = cfd_pkg::PH_FUNC;
			end
			cfd_pkg::PH_FUNC: begin
				func_d  = rx_byte;
				crc_d   = crc_fold_byte;
				phase_d = cfd_pkg::PH_LEN;
			end
			cfd_pkg::PH_LEN: begin
				len_d   = rx_byte;
				count_d = 8'd0;
				crc_d   = crc_fold_byte;
				phase_d = (rx_byte == 8'd0) ? cfd_pkg::PH_CRCLO : cfd_pkg::PH_DATA;
			end
			cfd_pkg::PH_DATA: begin
				crc_d      = crc_fold_byte;
				count_d    = count_inc;
				has_result = 1'b1;
				result.kind         = cfd_pkg::KIND_PAYLOAD;
				result.data_byte    = rx_byte;
				result.byte_index   = count_q;
				result.computed_crc = crc_fold_byte;
				if (count_inc == len_q) begin
					phase_d = cfd_pkg::PH_CRCLO;
				end
			end
			cfd_pkg::PH_CRCLO: begin
				crc_lo_d = rx_byte;
				phase_d  = cfd_pkg::PH_CRCHI;
			end
			cfd_pkg::PH_CRCHI: begin
				has_result = 1'b1;
				result.kind = (rx_crc == crc_q) ? cfd_pkg::KIND_GOOD : cfd_pkg::KIND_BAD;
				result.received_crc = rx_crc;
				result.computed_crc = crc_q;
				crc_d   = cfd_pkg::CRC_INIT;
				phase_d = cfd_pkg::PH_HUNT1;
			end
			default: begin
				phase_d = cfd_pkg::PH_HUNT1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= cfd_pkg::PH_HUNT1;
			crc_q    <= cfd_pkg::CRC_INIT;
			addr_q   <= 8'd0;
			func_q   <= 8'd0;
			len_q    <= 8'd0;
			count_q  <= 8'd0;
			crc_lo_q <= 8'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			addr_q   <= addr_d;
			func_q   <= func_d;
			len_q    <= len_d;
			count_q  <= count_d;
			crc_lo_q <= crc_lo_d;
		end
	end

endmodule

// ----- rtl/core/crc16_frame_deframer_top.sv -----
// top level of the crc-16 length-framed deframer: input register, parser, result register
// depends on cfd_pkg and cfd_parse
//
// Takes one received byte per word and sustains one byte per clock. A byte is held in
// an input register, where the frame state machine and a byte-wide crc update act on
// it, and any result lands in the output register: a payload result is presented there
// once its byte has passed the input register. Frames are AA 55,
// address, function, length, payload, crc low, crc high; every payload byte comes out
// as a payload word and the crc high byte yields a good or bad verdict. Bytes that
// produce no result never wait on the output side; a byte that makes a result waits in
// the input register while a result is held unread, and input stalls behind it.
module crc16_frame_deframer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [cfd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] rx_byte
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [7:0] data_byte, [15:8] byte_index, [23:16] address, [31:24] function_code,
	// [39:32] payload_length, [55:40] received_crc, [71:56] computed_crc
	output logic [cfd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic [cfd_pkg::KIND_W-1:0]       m_axis_tuser   // [1:0] kind
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             has_result;
	cfd_pkg::result_t result;
	cfd_pkg::result_t res_q;
	logic             out_valid_q;

	// the held byte moves on unless it makes a result and the output is still full
	assign advance       = valid_s1 && (!has_result || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata[7:0];
		end
	end

	cfd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte    (byte_s1),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tdata  = {res_q.computed_crc, res_q.received_crc, res_q.payload_length,
		res_q.function_code, res_q.address, res_q.byte_index, res_q.data_byte};

endmodule
